/* design/ibm_pkg.sv */
// package with shared types, constants and box helpers for the box merge table
package ibm_pkg;

  localparam int MaxBoxes = 64;
  localparam int ImageMax = 4096;
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int IdxW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_HALF_WIDTH   = 2'd2,
    REG_HALF_HEIGHT  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_SCAN,
    ST_MERGE,
    ST_FLUSH,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic        op;
    logic [11:0] point_x;
    logic [11:0] point_y;
  } req_t;

  typedef struct packed {
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [12:0] box_width;
    logic [12:0] box_height;
    logic        box_valid;
    logic        last_box;
    logic        table_overflowed;
  } rsp_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] width;
    logic [12:0] height;
  } box_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } cell_flag_t;

  typedef struct packed {
    logic       shift;
    logic       load;
    logic       append;
    logic       merge;
    logic [IdxW-1:0] merge_idx;
    logic       clear;
  } cell_ctrl_t;

  // clip span [lo, hi) to [0, size), signed 15-bit inputs
  function automatic logic [24:0] clip_span(input logic signed [14:0] lo,
                                            input logic signed [14:0] hi,
                                            input logic [12:0] size);
    logic signed [14:0] s;
    logic signed [14:0] e;
    logic signed [14:0] sz;
    logic [12:0] len;
    sz = $signed({2'b00, size});
    s = (lo < 0) ? 15'sd0 : ((lo > sz - 15'sd1) ? sz - 15'sd1 : lo);
    e = (hi < 0) ? 15'sd0 : ((hi > sz) ? sz : hi);
    len = (e > s) ? 13'(e - s) : 13'd0;
    return {s[11:0], len};
  endfunction

endpackage

/* design/ibm_cell.sv */
// one table cell: holds a box, checks overlap against the broadcast box, shifts on flush
module ibm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ibm_pkg::box_t       cand_i,
  input  logic                shift_i,
  input  logic                load_i,
  input  ibm_pkg::box_t       load_box_i,
  input  ibm_pkg::box_t       nbr_box_i,
  input  logic                nbr_valid_i,
  input  logic                clear_i,
  output ibm_pkg::box_t       box_o,
  output logic                valid_o,
  output logic                hit_o
);

  ibm_pkg::box_t box_q;
  logic          valid_q;
  logic [13:0]   sx, ex, sy, ey, nr, orr, nb, ob;
  logic signed [15:0] iw, ih;
  logic [24:0]   inter, an, ao;
  logic [27:0]   lhs, uni;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= nbr_valid_i;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      box_q <= nbr_box_i;
    end else if (load_i) begin
      box_q <= load_box_i;
    end
  end

  always_comb begin
    nr  = 14'(cand_i.left) + 14'(cand_i.width);
    orr = 14'(box_q.left) + 14'(box_q.width);
    nb  = 14'(cand_i.top) + 14'(cand_i.height);
    ob  = 14'(box_q.top) + 14'(box_q.height);
    sx  = (cand_i.left < box_q.left) ? 14'(cand_i.left) : 14'(box_q.left);
    ex  = (nr > orr) ? nr : orr;
    sy  = (cand_i.top < box_q.top) ? 14'(cand_i.top) : 14'(box_q.top);
    ey  = (nb > ob) ? nb : ob;
    iw  = $signed(16'(cand_i.width) + 16'(box_q.width)) - $signed(16'(ex - sx));
    ih  = $signed(16'(cand_i.height) + 16'(box_q.height)) - $signed(16'(ey - sy));
    inter = 25'(iw[12:0]) * 25'(ih[12:0]);
    an  = 25'(cand_i.width) * 25'(cand_i.height);
    ao  = 25'(box_q.width) * 25'(box_q.height);
    lhs = 28'(inter) * 28'd10;
    uni = 28'(an) + 28'(ao) - 28'(inter);
    hit_o = valid_q && (iw > 0) && (ih > 0) && (lhs >= uni);
  end

  assign box_o   = box_q;
  assign valid_o = valid_q;

endmodule

/* design/ibm_chain.sv */
// row of cells with first-hit priority and flush shift toward cell zero
module ibm_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ibm_pkg::box_t                 cand_i,
  input  ibm_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ibm_pkg::IdxW-1:0]      app_idx_i,
  input  ibm_pkg::box_t                 merge_box_i,
  output logic                          any_hit_o,
  output logic [ibm_pkg::IdxW-1:0]      hit_idx_o,
  output ibm_pkg::box_t                 hit_box_o,
  output ibm_pkg::box_t                 head_box_o,
  output logic                          head_valid_o,
  output logic                          second_valid_o
);

  localparam int N = ibm_pkg::MaxBoxes;

  ibm_pkg::box_t box_w [N+1];
  logic          valid_w [N+1];
  logic [N-1:0]  hit_w;
  logic [N-1:0]  load_w;

  assign box_w[N]   = '0;
  assign valid_w[N] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign load_w[g] = (ctrl_i.append && app_idx_i == ibm_pkg::IdxW'(g)) ||
                       (ctrl_i.merge && ctrl_i.merge_idx == ibm_pkg::IdxW'(g));
    ibm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cand_i      (cand_i),
      .shift_i     (ctrl_i.shift),
      .load_i      (load_w[g]),
      .load_box_i  (ctrl_i.merge ? merge_box_i : cand_i),
      .nbr_box_i   (box_w[g+1]),
      .nbr_valid_i (valid_w[g+1]),
      .clear_i     (ctrl_i.clear),
      .box_o       (box_w[g]),
      .valid_o     (valid_w[g]),
      .hit_o       (hit_w[g])
    );
  end

  always_comb begin
    hit_idx_o = '0;
    hit_box_o = box_w[0];
    for (int i = N - 1; i >= 0; i--) begin
      if (hit_w[i]) begin
        hit_idx_o = ibm_pkg::IdxW'(i);
        hit_box_o = box_w[i];
      end
    end
  end

  assign any_hit_o      = |hit_w;
  assign head_box_o     = box_w[0];
  assign head_valid_o   = valid_w[0];
  assign second_valid_o = (N > 1) ? valid_w[1] : 1'b0;

endmodule

/* design/iou_box_merge_table_top.sv */
// top level of the greedy box merge table
//  channel | direction | handshake
//  req     | in        | req_valid_i / req_ready_o, req_i
//  rsp     | out       | rsp_valid_o / rsp_ready_i, rsp_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i
// an add passes through accept, clip, then compare against all cells
// and append; a merge then goes on to the merge state to store the union
// a flush sends the stored boxes from cell zero on and holds on each output stall;
// a flush of an empty table gives one result
// reset empties every cell and clears the overflow flag
// output stalls hold the chain; no new request is taken until the flush is done
module iou_box_merge_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ibm_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ibm_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [12:0]   cfg_data_i
);

  ibm_pkg::state_e state_q, state_d;
  logic [12:0] img_w_q, img_h_q;
  logic [10:0] half_w_q, half_h_q;
  logic [11:0] px_q, py_q;
  ibm_pkg::box_t cand_q;
  logic [ibm_pkg::CntW-1:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic        any_hit;
  logic [ibm_pkg::IdxW-1:0] hit_idx, hit_idx_q;
  ibm_pkg::box_t hit_box, head_box, merge_box, cand_d;
  logic        head_valid, second_valid;
  ibm_pkg::cell_ctrl_t ctrl;
  logic [12:0] eff_w, eff_h;
  logic [24:0] cx, cy, mx, my;
  logic [13:0] ex, ey;
  ibm_pkg::box_t hit_box_q;

  assign cfg_ready_o = 1'b1;
  assign req_ready_o = (state_q == ibm_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= 13'd4096;
      img_h_q  <= 13'd4096;
      half_w_q <= 11'd30;
      half_h_q <= 11'd30;
    end else if (cfg_valid_i) begin
      case (ibm_pkg::reg_idx_e'(cfg_index_i))
        ibm_pkg::REG_IMAGE_WIDTH:  img_w_q  <= cfg_data_i;
        ibm_pkg::REG_IMAGE_HEIGHT: img_h_q  <= cfg_data_i;
        ibm_pkg::REG_HALF_WIDTH:   half_w_q <= cfg_data_i[10:0];
        ibm_pkg::REG_HALF_HEIGHT:  half_h_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = (img_w_q == 13'd0) ? 13'd1 :
            (img_w_q > 13'(ibm_pkg::ImageMax)) ? 13'(ibm_pkg::ImageMax) : img_w_q;
    eff_h = (img_h_q == 13'd0) ? 13'd1 :
            (img_h_q > 13'(ibm_pkg::ImageMax)) ? 13'(ibm_pkg::ImageMax) : img_h_q;
    cx = ibm_pkg::clip_span($signed({3'b000, px_q}) - $signed({4'b0000, half_w_q}),
                            $signed({3'b000, px_q}) + $signed({4'b0000, half_w_q}), eff_w);
    cy = ibm_pkg::clip_span($signed({3'b000, py_q}) - $signed({4'b0000, half_h_q}),
                            $signed({3'b000, py_q}) + $signed({4'b0000, half_h_q}), eff_h);
    cand_d = '{left: cx[24:13], top: cy[24:13], width: cx[12:0], height: cy[12:0]};
    ex = (14'(cand_q.left) + 14'(cand_q.width) > 14'(hit_box_q.left) + 14'(hit_box_q.width)) ?
         14'(cand_q.left) + 14'(cand_q.width) : 14'(hit_box_q.left) + 14'(hit_box_q.width);
    ey = (14'(cand_q.top) + 14'(cand_q.height) > 14'(hit_box_q.top) + 14'(hit_box_q.height)) ?
         14'(cand_q.top) + 14'(cand_q.height) : 14'(hit_box_q.top) + 14'(hit_box_q.height);
    mx = ibm_pkg::clip_span(
           $signed({3'b000, (cand_q.left < hit_box_q.left) ? cand_q.left : hit_box_q.left}),
           $signed({1'b0, ex}), eff_w);
    my = ibm_pkg::clip_span(
           $signed({3'b000, (cand_q.top < hit_box_q.top) ? cand_q.top : hit_box_q.top}),
           $signed({1'b0, ey}), eff_h);
    merge_box = '{left: mx[24:13], top: my[24:13], width: mx[12:0], height: my[12:0]};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ibm_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.op == ibm_pkg::OP_FLUSH) begin
            state_d = (count_q == '0) ? ibm_pkg::ST_EMPTY : ibm_pkg::ST_FLUSH;
          end else begin
            state_d = ibm_pkg::ST_CLIP;
          end
        end
      end
      ibm_pkg::ST_CLIP:  state_d = ibm_pkg::ST_SCAN;
      ibm_pkg::ST_SCAN:  state_d = any_hit ? ibm_pkg::ST_MERGE : ibm_pkg::ST_IDLE;
      ibm_pkg::ST_MERGE: state_d = ibm_pkg::ST_IDLE;
      ibm_pkg::ST_FLUSH: if (rsp_ready_i && !second_valid) state_d = ibm_pkg::ST_IDLE;
      ibm_pkg::ST_EMPTY: if (rsp_ready_i) state_d = ibm_pkg::ST_IDLE;
      default: state_d = ibm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    count_d = count_q;
    ovf_d = ovf_q;
    rsp_valid_o = 1'b0;
    rsp_o = '0;
    case (state_q)
      ibm_pkg::ST_SCAN: begin
        if (!any_hit) begin
          if (count_q < ibm_pkg::CntW'(ibm_pkg::MaxBoxes)) begin
            ctrl.append = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ibm_pkg::ST_MERGE: begin
        ctrl.merge = 1'b1;
        ctrl.merge_idx = hit_idx_q;
      end
      ibm_pkg::ST_FLUSH: begin
        rsp_valid_o = 1'b1;
        rsp_o = '{box_left: head_box.left, box_top: head_box.top,
                  box_width: head_box.width, box_height: head_box.height,
                  box_valid: 1'b1, last_box: !second_valid, table_overflowed: ovf_q};
        if (rsp_ready_i) begin
          ctrl.shift = 1'b1;
          if (!second_valid) begin
            count_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      ibm_pkg::ST_EMPTY: begin
        rsp_valid_o = 1'b1;
        rsp_o.last_box = 1'b1;
        rsp_o.table_overflowed = ovf_q;
        if (rsp_ready_i) ovf_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibm_pkg::ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      px_q <= req_i.point_x;
      py_q <= req_i.point_y;
    end
    if (state_q == ibm_pkg::ST_CLIP) cand_q <= cand_d;
    if (state_q == ibm_pkg::ST_SCAN) begin
      hit_idx_q <= hit_idx;
      hit_box_q <= hit_box;
    end
  end

  ibm_chain u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cand_i         (cand_q),
    .ctrl_i         (ctrl),
    .app_idx_i      (count_q[ibm_pkg::IdxW-1:0]),
    .merge_box_i    (merge_box),
    .any_hit_o      (any_hit),
    .hit_idx_o      (hit_idx),
    .hit_box_o      (hit_box),
    .head_box_o     (head_box),
    .head_valid_o   (head_valid),
    .second_valid_o (second_valid)
  );

  a_flush_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ibm_pkg::ST_FLUSH |-> head_valid)
    else $error("flush without stored box");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ibm_pkg::CntW'(ibm_pkg::MaxBoxes))
    else $error("count above capacity");
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> !head_valid)
    else $error("cell valid with zero count");
  a_flush_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibm_pkg::ST_FLUSH && rsp_ready_i && !second_valid) |=> count_q == '0 && !ovf_q)
    else $error("flush did not clear table");

endmodule

/* tb/sv/tb_top.sv */
// testbench for the greedy box merge table: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    int left;
    int top;
    int width;
    int height;
  } pbox_t;

  logic          clk;
  logic          rst_n;
  logic          req_valid;
  logic          req_ready;
  ibm_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  ibm_pkg::rsp_t rsp;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [12:0]   cfg_data;

  pbox_t boxes[ibm_pkg::MaxBoxes];
  int    box_count;
  bit    overflow;
  int    img_w, img_h, half_w, half_h;

  ibm_pkg::rsp_t expected_boxes[$];
  int    mismatches;
  int    checked;
  int    send_idle_pct;
  int    recv_idle_pct;
  int    hold_cycles;

  iou_box_merge_table_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("iou_box_merge_table_top test failed");
    $finish;
  end

  function automatic int eff_size(int r);
    if (r < 1) return 1;
    if (r > ibm_pkg::ImageMax) return ibm_pkg::ImageMax;
    return r;
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pbox_t clip_to_image(int l, int t, int r, int b);
    pbox_t o;
    int    sw, sh, e;
    sw = eff_size(img_w);
    sh = eff_size(img_h);
    o.left = clamp(l, 0, sw - 1);
    e = clamp(r, 0, sw);
    o.width = (e > o.left) ? e - o.left : 0;
    o.top = clamp(t, 0, sh - 1);
    e = clamp(b, 0, sh);
    o.height = (e > o.top) ? e - o.top : 0;
    return o;
  endfunction

  task automatic predict_add(int px, int py);
    pbox_t nb, ob;
    int    l, t, sx, ex, sy, ey, iw, ih;
    longint inter, uni;
    l = px - half_w;
    t = py - half_h;
    nb = clip_to_image(l, t, l + 2 * half_w, t + 2 * half_h);
    for (int m = 0; m < box_count; m++) begin
      ob = boxes[m];
      sx = (nb.left < ob.left) ? nb.left : ob.left;
      ex = (nb.left + nb.width > ob.left + ob.width) ? nb.left + nb.width : ob.left + ob.width;
      sy = (nb.top < ob.top) ? nb.top : ob.top;
      ey = (nb.top + nb.height > ob.top + ob.height) ? nb.top + nb.height
                                                     : ob.top + ob.height;
      iw = nb.width + ob.width - (ex - sx);
      ih = nb.height + ob.height - (ey - sy);
      if (iw > 0 && ih > 0) begin
        inter = longint'(iw) * ih;
        uni = longint'(nb.width) * nb.height + longint'(ob.width) * ob.height - inter;
        if (10 * inter >= uni) begin
          boxes[m] = clip_to_image(sx, sy, ex, ey);
          return;
        end
      end
    end
    if (box_count < ibm_pkg::MaxBoxes) begin
      boxes[box_count] = nb;
      box_count++;
    end else begin
      overflow = 1'b1;
    end
  endtask

  task automatic predict_flush();
    ibm_pkg::rsp_t r;
    if (box_count == 0) begin
      r = '0;
      r.last_box = 1'b1;
      r.table_overflowed = overflow;
      expected_boxes = {expected_boxes, r};
    end
    for (int k = 0; k < box_count; k++) begin
      r.box_left = boxes[k].left[11:0];
      r.box_top = boxes[k].top[11:0];
      r.box_width = boxes[k].width[12:0];
      r.box_height = boxes[k].height[12:0];
      r.box_valid = 1'b1;
      r.last_box = (k + 1 == box_count);
      r.table_overflowed = overflow;
      expected_boxes = {expected_boxes, r};
    end
    box_count = 0;
    overflow = 1'b0;
  endtask

  task automatic send_request(ibm_pkg::op_e op, int px, int py);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req.op <= op;
    req.point_x <= px[11:0];
    req.point_y <= py[11:0];
    if (op == ibm_pkg::OP_ADD) predict_add(px, py);
    else predict_flush();
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(ibm_pkg::reg_idx_e idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ibm_pkg::REG_IMAGE_WIDTH:  img_w = value & 13'h1fff;
      ibm_pkg::REG_IMAGE_HEIGHT: img_h = value & 13'h1fff;
      ibm_pkg::REG_HALF_WIDTH:   half_w = value & 11'h7ff;
      default:                   half_h = value & 11'h7ff;
    endcase
  endtask

  task automatic set_config(int w, int h, int hw, int hh);
    wait_drained();
    write_reg(ibm_pkg::REG_IMAGE_WIDTH, w);
    write_reg(ibm_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(ibm_pkg::REG_HALF_WIDTH, hw);
    write_reg(ibm_pkg::REG_HALF_HEIGHT, hh);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    send_request(ibm_pkg::OP_ADD, 0, 0);
    send_request(ibm_pkg::OP_ADD, 4095, 4095);
    send_request(ibm_pkg::OP_ADD, 10, 10);
    send_request(ibm_pkg::OP_ADD, 4080, 4090);
    send_request(ibm_pkg::OP_ADD, 2000, 2000);
    send_request(ibm_pkg::OP_ADD, 2030, 2010);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    set_config(100, 80, 0, 5);
    send_request(ibm_pkg::OP_ADD, 50, 40);
    send_request(ibm_pkg::OP_ADD, 3000, 3000);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    set_config(0, 8191, 2047, 2047);
    send_request(ibm_pkg::OP_ADD, 0, 4095);
    send_request(ibm_pkg::OP_ADD, 2048, 1234);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    set_config(4096, 4096, 1, 1);
    send_request(ibm_pkg::OP_ADD, 100, 100);
    send_request(ibm_pkg::OP_ADD, 101, 101);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
  endtask

  task automatic test_overflow();
    set_config(4096, 4096, 2, 2);
    for (int i = 0; i < ibm_pkg::MaxBoxes + 3; i++) begin
      send_request(ibm_pkg::OP_ADD, 20 * i + 5, 30);
    end
    send_request(ibm_pkg::OP_ADD, 45, 30);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
  endtask

  task automatic test_random(int count, int span);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(14) == 0) send_request(ibm_pkg::OP_FLUSH, $urandom, $urandom);
      else if ($urandom_range(9) == 0) send_request(ibm_pkg::OP_ADD, $urandom_range(4095),
                                                      $urandom_range(4095));
      else send_request(ibm_pkg::OP_ADD, $urandom_range(span), $urandom_range(span));
    end
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) send_request(ibm_pkg::OP_ADD, 40 * i, 40 * i);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
    send_request(ibm_pkg::OP_ADD, 7, 7);
    send_request(ibm_pkg::OP_FLUSH, 0, 0);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && rsp_valid && rsp_ready) begin
      checked++;
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        if (rsp !== expected_boxes[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_boxes[0], rsp);
        end
        void'(expected_boxes.pop_front());
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ibm_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    hold_cycles = 0;
    mismatches = 0;
    checked = 0;
    box_count = 0;
    overflow = 1'b0;
    img_w = 4096;
    img_h = 4096;
    half_w = 30;
    half_h = 30;
    send_idle_pct = 35;
    recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    set_config(640, 480, 30, 30);
    test_random(35, 700);
    send_idle_pct = 65;
    recv_idle_pct = 35;
    set_config(1, 4096, 7, 300);
    test_random(20, 4095);
    set_config(300, 200, 12, 9);
    test_random(30, 320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(4096, 4096, 60, 60);
    test_random(40, 1500);
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_boxes.size() != 0) mismatches++;
    $display("covered adds, flushes of empty and full tables, overflow, merges and clipping");
    $display("results checked: %0d, mismatches: %0d", checked, mismatches);
    if (mismatches == 0) begin
      $display("iou_box_merge_table_top test passed");
    end else begin
      $display("iou_box_merge_table_top test failed");
    end
    $finish;
  end

endmodule
